>>> rtl/lapshp_pkg.sv
`timescale 1ns / 1ps

package lapshp_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_CHANNELS = 4;

    localparam int LS_DEPTH = 4096;
    localparam int LS_AW    = $clog2(LS_DEPTH);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int CFG_DIM_W  = 11;
    localparam int CFG_CH_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int PIX_W = 8;
    localparam int ACC_W = 12;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_CH_W-1:0]  CHAN_RESET   = 3'd3;
    localparam logic [CFG_DIM_W-1:0] DIM_MIN      = 11'd3;
    localparam logic [CFG_CH_W-1:0]  CHAN_MIN     = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        MODE_FILL  = 2'b01,
        MODE_DRAIN = 2'b10
    } t_mode;

    typedef struct packed {
        logic             emit;
        logic             pixel;
        logic             interior;
        logic             frame_end;
        logic             sel;
        logic [PIX_W-1:0] sample;
    } t_s1_info;

endpackage

>>> rtl/lapshp_lines.sv
`timescale 1ns / 1ps

module lapshp_lines (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [lapshp_pkg::LS_AW-1:0]   i_rd_addr0,
    input  logic [lapshp_pkg::LS_AW-1:0]   i_rd_addr1,
    input  logic                           i_we_a,
    input  logic                           i_we_b,
    input  logic [lapshp_pkg::LS_AW-1:0]   i_wr_addr,
    input  logic [lapshp_pkg::PIX_W-1:0]   i_wr_data,
    output logic [lapshp_pkg::PIX_W-1:0]   o_a0,
    output logic [lapshp_pkg::PIX_W-1:0]   o_a1,
    output logic [lapshp_pkg::PIX_W-1:0]   o_b0,
    output logic [lapshp_pkg::PIX_W-1:0]   o_b1
);
    import lapshp_pkg::*;

    logic [PIX_W-1:0] r_mem_a [LS_DEPTH];
    logic [PIX_W-1:0] r_mem_b [LS_DEPTH];

    // reads return the old entry when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_a0 <= r_mem_a[i_rd_addr0];
            o_a1 <= r_mem_a[i_rd_addr1];
        end
        if (i_we_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_b0 <= r_mem_b[i_rd_addr0];
            o_b1 <= r_mem_b[i_rd_addr1];
        end
        if (i_we_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

>>> rtl/lapshp_ctrl.sv
`timescale 1ns / 1ps

module lapshp_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [lapshp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lapshp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                 o_cfg_ready,
    input  logic                                 i_accept,
    input  logic                                 i_in_command,
    input  logic [lapshp_pkg::PIX_W-1:0]         i_in_sample,
    output logic [lapshp_pkg::LS_AW-1:0]         o_rd_addr0,
    output logic [lapshp_pkg::LS_AW-1:0]         o_rd_addr1,
    output logic                                 o_we_a,
    output logic                                 o_we_b,
    output logic [lapshp_pkg::PIX_W-1:0]         o_wr_data,
    output lapshp_pkg::t_s1_info                 o_s1_info,
    output logic [lapshp_pkg::CH_W-1:0]          o_chan_m1
);
    import lapshp_pkg::*;

    logic [CFG_DIM_W-1:0] r_width, r_height;
    logic [CFG_CH_W-1:0]  r_chans;

    logic [LS_AW-1:0] r_pos, n_pos;
    logic [CH_W-1:0]  r_chan, n_chan;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_sel, n_sel;
    t_mode            r_mode, n_mode;
    t_s1_info         r_s1_info;

    logic [CFG_DIM_W-1:0]          eff_w, eff_h;
    logic [CFG_CH_W-1:0]           eff_c;
    logic [COL_W-1:0]              w_m1;
    logic [ROW_W-1:0]              h_m1;
    logic [CH_W-1:0]               c_m1;
    logic [CFG_DIM_W+CFG_CH_W-1:0] row_bytes;
    logic [LS_AW-1:0]              row_last;
    logic                          cfg_wr, pix, drn, row_end;

    // registers are used clamped to their legal range
    always_comb begin
        if (r_width < DIM_MIN) begin
            eff_w = DIM_MIN;
        end else if (r_width > CFG_DIM_W'(MAX_WIDTH)) begin
            eff_w = CFG_DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        if (r_height < DIM_MIN) begin
            eff_h = DIM_MIN;
        end else if (r_height > CFG_DIM_W'(MAX_HEIGHT)) begin
            eff_h = CFG_DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
        if (r_chans < CHAN_MIN) begin
            eff_c = CHAN_MIN;
        end else if (r_chans > CFG_CH_W'(MAX_CHANNELS)) begin
            eff_c = CFG_CH_W'(MAX_CHANNELS);
        end else begin
            eff_c = r_chans;
        end
    end

    assign w_m1      = COL_W'(eff_w - CFG_DIM_W'(1));
    assign h_m1      = ROW_W'(eff_h - CFG_DIM_W'(1));
    assign c_m1      = CH_W'(eff_c - CFG_CH_W'(1));
    assign row_bytes = {{CFG_CH_W{1'b0}}, eff_w} * {{CFG_DIM_W{1'b0}}, eff_c};
    assign row_last  = LS_AW'(row_bytes - (CFG_DIM_W + CFG_CH_W)'(1));

    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign pix     = i_accept && (i_in_command == CMD_PIXEL) && (r_mode == MODE_FILL);
    assign drn     = i_accept && (i_in_command == CMD_DRAIN) && (r_mode == MODE_DRAIN);
    assign row_end = (r_pos == row_last);

    always_comb begin
        n_pos  = r_pos;
        n_chan = r_chan;
        n_col  = r_col;
        n_row  = r_row;
        n_sel  = r_sel;
        n_mode = r_mode;
        if (cfg_wr && (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT
                       || i_cfg_index == CFG_CHANNEL_COUNT)) begin
            n_pos  = '0;
            n_chan = '0;
            n_col  = '0;
            n_row  = '0;
            n_sel  = 1'b0;
            n_mode = MODE_FILL;
        end else if (pix) begin
            if (row_end) begin
                n_pos  = '0;
                n_chan = '0;
                n_col  = '0;
                n_sel  = ~r_sel;
                if (r_row == h_m1) begin
                    n_mode = MODE_DRAIN;
                    n_row  = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_pos = r_pos + LS_AW'(1);
                if (r_chan == c_m1) begin
                    n_chan = '0;
                    n_col  = r_col + COL_W'(1);
                end else begin
                    n_chan = r_chan + CH_W'(1);
                end
            end
        end else if (drn) begin
            if (row_end) begin
                n_pos  = '0;
                n_chan = '0;
                n_col  = '0;
                n_row  = '0;
                n_sel  = 1'b0;
                n_mode = MODE_FILL;
            end else begin
                n_pos = r_pos + LS_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_chans  <= CHAN_RESET;
            r_pos    <= '0;
            r_chan   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_sel    <= 1'b0;
            r_mode   <= MODE_FILL;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data;
                    end
                    CFG_CHANNEL_COUNT: begin
                        r_chans <= i_cfg_data[CFG_CH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_pos  <= n_pos;
            r_chan <= n_chan;
            r_col  <= n_col;
            r_row  <= n_row;
            r_sel  <= n_sel;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_info.emit      <= (pix && (r_row != '0)) || drn;
            r_s1_info.pixel     <= pix;
            r_s1_info.interior  <= pix && (r_row != '0) && (r_row != ROW_W'(1))
                                   && (r_col != '0) && (r_col != w_m1);
            r_s1_info.frame_end <= drn && row_end;
            r_s1_info.sel       <= r_sel;
            r_s1_info.sample    <= i_in_sample;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_rd_addr0  = r_pos;
    assign o_rd_addr1  = r_pos + LS_AW'(eff_c);
    assign o_we_a      = pix && r_sel;
    assign o_we_b      = pix && !r_sel;
    assign o_wr_data   = i_in_sample;
    assign o_s1_info   = r_s1_info;
    assign o_chan_m1   = c_m1;

`ifndef NO_ASSERTIONS
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_m1) else $error("column counter past row end");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= row_last) else $error("byte position past row end");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_m1) else $error("row counter past frame end");
`endif

endmodule

>>> rtl/lapshp_calc.sv
`timescale 1ns / 1ps

module lapshp_calc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  lapshp_pkg::t_s1_info           i_info,
    input  logic [lapshp_pkg::CH_W-1:0]    i_chan_m1,
    input  logic [lapshp_pkg::PIX_W-1:0]   i_a0,
    input  logic [lapshp_pkg::PIX_W-1:0]   i_a1,
    input  logic [lapshp_pkg::PIX_W-1:0]   i_b0,
    input  logic [lapshp_pkg::PIX_W-1:0]   i_b1,
    input  logic                           i_out_stall,
    output logic                           o_s1_free,
    output logic                           o_out_valid,
    output logic [lapshp_pkg::PIX_W-1:0]   o_out_value,
    output logic                           o_out_frame_end
);
    import lapshp_pkg::*;

    logic             r_s1_valid;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_frame_end;
    logic [PIX_W-1:0] r_line [MAX_CHANNELS];

    logic             out_free, s1_move;
    logic [PIX_W-1:0] center, right, above, left, sat;
    logic [ACC_W-1:0] acc;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_move   = r_s1_valid && out_free;
    assign o_s1_free = !r_s1_valid || out_free;

    // previous row sits in b when sel is set, the row above it in a
    assign center = i_info.sel ? i_b0 : i_a0;
    assign right  = i_info.sel ? i_b1 : i_a1;
    assign above  = i_info.sel ? i_a0 : i_b0;
    assign left   = r_line[i_chan_m1];

    assign acc = ACC_W'({center, 2'b00}) + ACC_W'(center)
               - ACC_W'(left) - ACC_W'(right) - ACC_W'(above) - ACC_W'(i_info.sample);

    always_comb begin
        if (acc[ACC_W-1]) begin
            sat = '0;
        end else if (acc[ACC_W-2:PIX_W] != '0) begin
            sat = '1;
        end else begin
            sat = acc[PIX_W-1:0];
        end
    end

    // centre bytes of the last few pixel requests give the left neighbour
    always_ff @(posedge i_clk) begin
        if (s1_move && i_info.pixel) begin
            r_line[0] <= center;
            for (int k = 1; k < MAX_CHANNELS; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= i_info.emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value     <= i_info.interior ? sat : '0;
            r_out_frame_end <= i_info.frame_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_value     = r_out_value;
    assign o_out_frame_end = r_out_frame_end;

`ifndef NO_ASSERTIONS
    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && i_info.emit |=> r_out_valid) else $error("request lost in output stage");
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && i_info.emit && !i_info.interior |=> r_out_value == '0)
        else $error("border byte not zero");
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_frame_end |-> r_out_value == '0)
        else $error("frame end byte not zero");
`endif

endmodule

>>> rtl/laplacian_sharpen_3x3_top.sv
`timescale 1ns / 1ps

// channel  direction  signals
// in       to block   i_in_valid, o_in_stall, i_in_command, i_in_sample
// out      from block o_out_valid, i_out_stall, o_out_value, o_out_frame_end
// cfg      to block   i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// one request per cycle while o_in_stall is low; a result passes through
// the line store read register and then the output register
// synchronous active-low reset, no clearing pass; line stores keep contents
// o_in_stall follows i_out_stall only while both pipeline stages are full

module laplacian_sharpen_3x3_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lapshp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lapshp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_in_command,
    input  logic [lapshp_pkg::PIX_W-1:0]         i_in_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lapshp_pkg::PIX_W-1:0]         o_out_value,
    output logic                                 o_out_frame_end
);
    import lapshp_pkg::*;

    logic             s1_free, accept;
    logic [LS_AW-1:0] rd_addr0, rd_addr1;
    logic             we_a, we_b;
    logic [PIX_W-1:0] wr_data;
    logic [PIX_W-1:0] a0, a1, b0, b1;
    logic [CH_W-1:0]  chan_m1;
    t_s1_info         s1_info;

    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    lapshp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_accept     (accept),
        .i_in_command (i_in_command),
        .i_in_sample  (i_in_sample),
        .o_rd_addr0   (rd_addr0),
        .o_rd_addr1   (rd_addr1),
        .o_we_a       (we_a),
        .o_we_b       (we_b),
        .o_wr_data    (wr_data),
        .o_s1_info    (s1_info),
        .o_chan_m1    (chan_m1)
    );

    lapshp_lines u_lines (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .i_we_a     (we_a),
        .i_we_b     (we_b),
        .i_wr_addr  (rd_addr0),
        .i_wr_data  (wr_data),
        .o_a0       (a0),
        .o_a1       (a1),
        .o_b0       (b0),
        .o_b1       (b1)
    );

    lapshp_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_info          (s1_info),
        .i_chan_m1       (chan_m1),
        .i_a0            (a0),
        .i_a1            (a1),
        .i_b0            (b0),
        .i_b1            (b1),
        .i_out_stall     (i_out_stall),
        .o_s1_free       (s1_free),
        .o_out_valid     (o_out_valid),
        .o_out_value     (o_out_value),
        .o_out_frame_end (o_out_frame_end)
    );

endmodule
